### src/query_slot_range_tracker_top_macros.svh
// Assertion macros shared by the checker. Clock aclk, reset aresetn (active low).
`ifndef QUERY_SLOT_RANGE_TRACKER_TOP_MACROS_SVH
`define QUERY_SLOT_RANGE_TRACKER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QSRT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QSRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/qsrt_pkg.sv
`timescale 1ns / 1ps

package qsrt_pkg;

    localparam int POOL_DEPTH_DEF = 64;
    localparam logic [6:0] POOL_SIZE_RST = 7'd64;

    typedef enum logic [1:0] {
        OP_RESET   = 2'd0,
        OP_SUBMIT  = 2'd1,
        OP_RESOLVE = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    // Slot and range states share one encoding.
    localparam logic [1:0] ST_RESET    = 2'd0;
    localparam logic [1:0] ST_PENDING  = 2'd1;
    localparam logic [1:0] ST_RESOLVED = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [6:0]  first_slot;
        logic [6:0]  slot_count;
        logic [63:0] submission_id;
    } qsrt_in_t;

    typedef struct packed {
        logic        status;
        logic [1:0]  range_state;
        logic [63:0] max_submission;
    } qsrt_out_t;

    typedef struct packed {
        logic [1:0]  state;
        logic [63:0] id;
    } slot_t;

endpackage

### src/query_slot_range_tracker_top.sv
`timescale 1ns / 1ps

// Query slot range tracker.
// Input channel s_valid/s_ready/s_data carries one command beat: opcode, first
// slot, slot count and submission id. Output channel m_valid/m_ready/m_data
// returns exactly one result beat per command: status, range state, max id.
// cfg_wr_en/cfg_wr_data write pool_size; write it only while the block is idle.
// Sequencing: the slot memory and one shared 64-bit comparator visit the slots
// of the range one at a time. Reset and submit write each slot in the issue
// state, then load the result beat; resolve and query read each slot in the
// issue state and compare in the eval state, where resolve marks pending slots
// with an id not above the command's id resolved. A query stops at the first
// reset slot. Invalid or empty ranges go straight to done. One command is in
// flight at a time; s_ready returns as the result beat is loaded, so the next
// command is taken only once the previous result is in the output register.
// A result waits in the output register while m_ready is low; the next command
// may still be accepted and processed, and then holds until the register frees.
// Reset (aresetn low, synchronous) clears all slots to reset with id 0 via
// per-slot valid bits and sets pool_size to 64.
module query_slot_range_tracker_top
    import qsrt_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  qsrt_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output qsrt_out_t m_data,
    input  logic      cfg_wr_en,
    input  logic [6:0] cfg_wr_data
);

    // Ranges never reach past slot 126, so at most 127 entries are stored.
    localparam int MEM_DEPTH = (POOL_DEPTH < 127) ? POOL_DEPTH : 127;
    localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [6:0] P_CAP = 7'(MEM_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_EVAL,
        S_DONE
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  op_reg, op_next;
    logic [6:0]  first_reg, first_next;
    logic [6:0]  count_reg, count_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] id_reg, id_next;
    logic        bad_reg, bad_next;
    logic        pend_reg, pend_next;
    logic        rst_hit_reg, rst_hit_next;
    logic [63:0] maxid_reg, maxid_next;
    logic [6:0]  pool_size_reg, pool_size_next;
    logic        m_valid_reg, m_valid_next;
    qsrt_out_t   m_data_reg, m_data_next;

    logic [6:0]  eff_pool;
    logic        range_ok;
    logic [6:0]  slot_idx;
    logic [6:0]  cnt_inc;
    logic        last_slot;
    logic        wr_en;
    slot_t       wr_data;
    logic        rd_en;
    slot_t       rd_data;
    logic [63:0] cmp_b;
    logic        cmp_gt;
    qsrt_out_t   result;

    assign eff_pool = (pool_size_reg > P_CAP) ? P_CAP : pool_size_reg;

    always_comb begin
        if (s_data.slot_count == 7'd0) begin
            range_ok = (s_data.first_slot <= eff_pool);
        end else begin
            range_ok = (s_data.first_slot < eff_pool)
                    && (s_data.slot_count <= 7'(eff_pool - s_data.first_slot));
        end
    end

    assign slot_idx  = 7'(first_reg + cnt_reg);
    assign cnt_inc   = 7'(cnt_reg + 7'd1);
    assign last_slot = (cnt_inc == count_reg);

    // Resolve compares slot id against the completed id; query against running max.
    assign cmp_b = (op_reg == OP_RESOLVE) ? id_reg : maxid_reg;

    qsrt_cmp u_cmp (
        .a  (rd_data.id),
        .b  (cmp_b),
        .gt (cmp_gt)
    );

    always_comb begin
        wr_en   = 1'b0;
        wr_data = '0;
        rd_en   = 1'b0;
        if (state_reg == S_ISSUE) begin
            case (op_reg)
                OP_RESET: begin
                    wr_en   = 1'b1;
                    wr_data = '{state: ST_RESET, id: 64'd0};
                end
                OP_SUBMIT: begin
                    wr_en   = 1'b1;
                    wr_data = '{state: ST_PENDING, id: id_reg};
                end
                default: begin
                    rd_en = 1'b1;
                end
            endcase
        end else if (state_reg == S_EVAL && op_reg == OP_RESOLVE) begin
            wr_en   = (rd_data.state == ST_PENDING) && !cmp_gt;
            wr_data = '{state: ST_RESOLVED, id: rd_data.id};
        end
    end

    qsrt_store #(
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (slot_idx[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (slot_idx[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb begin
        result.status         = bad_reg ? STATUS_INVALID : STATUS_OK;
        result.range_state    = ST_RESET;
        result.max_submission = 64'd0;
        if (!bad_reg && op_reg == OP_QUERY && !rst_hit_reg) begin
            result.range_state    = pend_reg ? ST_PENDING : ST_RESOLVED;
            result.max_submission = maxid_reg;
        end
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        first_next     = first_reg;
        count_next     = count_reg;
        cnt_next       = cnt_reg;
        id_next        = id_reg;
        bad_next       = bad_reg;
        pend_next      = pend_reg;
        rst_hit_next   = rst_hit_reg;
        maxid_next     = maxid_reg;
        pool_size_next = cfg_wr_en ? cfg_wr_data : pool_size_reg;
        m_valid_next   = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        m_data_next    = m_data_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next      = s_data.opcode;
                    first_next   = s_data.first_slot;
                    count_next   = s_data.slot_count;
                    id_next      = s_data.submission_id;
                    cnt_next     = 7'd0;
                    bad_next     = !range_ok;
                    pend_next    = 1'b0;
                    rst_hit_next = 1'b0;
                    maxid_next   = 64'd0;
                    if (!range_ok || s_data.slot_count == 7'd0) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                if (op_reg == OP_RESET || op_reg == OP_SUBMIT) begin
                    cnt_next   = cnt_inc;
                    state_next = last_slot ? S_DONE : S_ISSUE;
                end else begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cnt_next   = cnt_inc;
                state_next = last_slot ? S_DONE : S_ISSUE;
                if (op_reg == OP_QUERY) begin
                    if (rd_data.state == ST_RESET) begin
                        // Any reset slot settles the answer; stop the walk.
                        rst_hit_next = 1'b1;
                        state_next   = S_DONE;
                    end else begin
                        if (rd_data.state == ST_PENDING) begin
                            pend_next = 1'b1;
                        end
                        if (cmp_gt) begin
                            maxid_next = rd_data.id;
                        end
                    end
                end
            end
            S_DONE: begin
                // Hold until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = result;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            pool_size_reg <= POOL_SIZE_RST;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            pool_size_reg <= pool_size_next;
        end
        op_reg      <= op_next;
        first_reg   <= first_next;
        count_reg   <= count_next;
        cnt_reg     <= cnt_next;
        id_reg      <= id_next;
        bad_reg     <= bad_next;
        pend_reg    <= pend_next;
        rst_hit_reg <= rst_hit_next;
        maxid_reg   <= maxid_next;
        m_data_reg  <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### src/qsrt_cmp.sv
`timescale 1ns / 1ps

// Shared 64-bit magnitude compare: gt is high when a > b (unsigned).
module qsrt_cmp
    import qsrt_pkg::*;
(
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        gt
);

    assign gt = (a > b);

endmodule

### src/qsrt_store.sv
`timescale 1ns / 1ps

// Slot memory: one write port, one registered read port. A per-entry valid
// bit, cleared at reset, makes unwritten entries read as reset state, id 0.
module qsrt_store
    import qsrt_pkg::*;
#(
    parameter int DEPTH = POOL_DEPTH_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  slot_t             wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output slot_t             rd_data
);

    slot_t            mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    slot_t            rd_word_reg;
    logic             rd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
            rd_hit_reg  <= vld_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_hit_reg ? rd_word_reg : '0;

endmodule

### src/qsrt_checker.sv
`timescale 1ns / 1ps
`include "query_slot_range_tracker_top_macros.svh"

module qsrt_checker
    import qsrt_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input qsrt_in_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input qsrt_out_t m_data,
    input logic      cfg_wr_en,
    input logic [6:0] cfg_wr_data
);

    logic unused_inputs;
    assign unused_inputs = ^{s_data, cfg_wr_en, cfg_wr_data};

    // A pending result beat is not withdrawn.
    `QSRT_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid, "result beat dropped while stalled")

    // The sequencer is busy in the cycle after it takes a command.
    `QSRT_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready after accept")

    // Invalid ranges carry no answer.
    `QSRT_ASSERT_SAME(a_invalid_clean, m_valid && (m_data.status == STATUS_INVALID), (m_data.range_state == ST_RESET) && (m_data.max_submission == 64'd0), "invalid result carries data")

    // A reset answer always reports id zero.
    `QSRT_ASSERT_SAME(a_reset_zero_id, m_valid && (m_data.range_state == ST_RESET), m_data.max_submission == 64'd0, "reset answer with nonzero id")

    // The range state is never the unused code.
    `QSRT_ASSERT_SAME(a_state_code, m_valid, m_data.range_state != 2'd3, "unused range state code")

endmodule

bind query_slot_range_tracker_top qsrt_checker u_qsrt_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_data      (s_data),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_data      (m_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
);
